FILE: hw/rtl/rlsf_pkg.sv
package rlsf_pkg;

    // field widths
    localparam int CoordW   = 15;
    localparam int ForcedW  = 16;
    localparam int DivW     = 8;
    localparam int StepW    = 8;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 15;

    // serial divider: one quotient bit per cycle over the distance width
    localparam int DivCntW  = $clog2(CoordW);

    // divisor value after reset
    localparam logic [DivW-1:0] DivReset = 8'd16;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] REG_ANCHOR_X   = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_ANCHOR_Y   = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_MAX_X      = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_MAX_Y      = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_CATCHUP    = 3'd4;

    // how the scroll registers are updated for one tick
    typedef enum logic [1:0] {
        MODE_FORCE  = 2'd0,
        MODE_JUMP   = 2'd1,
        MODE_FOLLOW = 2'd2
    } t_mode;

    // controller to datapath
    typedef struct packed {
        logic  load_in;
        logic  setup;
        logic  div_step;
        logic  update;
        t_mode mode;
        logic  load_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic forced;
    } t_status;

endpackage

FILE: hw/rtl/rlsf_ctrl.sv
module rlsf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_new_screen,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  rlsf_pkg::t_status i_status,
    output rlsf_pkg::t_cmd    o_cmd
);
    import rlsf_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_SETUP   = 5'b00010,
        S_DIV     = 5'b00100,
        S_UPDATE  = 5'b01000,
        S_PUBLISH = 5'b10000
    } t_state;

    t_state               r_state, n_state;
    t_mode                r_mode, n_mode;
    logic                 r_pending, n_pending;
    logic                 r_out_valid, n_out_valid;
    logic [DivCntW-1:0]   r_cnt, n_cnt;
    logic                 in_xfer;

    assign in_xfer     = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    // next-state and command decode
    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_pending   = r_pending;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd          = '0;
        o_cmd.mode     = r_mode;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    o_cmd.load_in = 1'b1;
                    n_pending     = r_pending | i_new_screen;
                    n_state       = S_SETUP;
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                priority if (i_status.forced) begin
                    n_mode  = MODE_FORCE;
                    n_state = S_UPDATE;
                end else if (r_pending) begin
                    n_mode    = MODE_JUMP;
                    n_pending = 1'b0;
                    n_state   = S_UPDATE;
                end else begin
                    n_mode  = MODE_FOLLOW;
                    n_cnt   = DivCntW'(CoordW - 1);
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_UPDATE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_PUBLISH;
            end
            S_PUBLISH: begin
                // wait until the output register is free or being taken
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_FOLLOW;
            r_pending   <= 1'b1;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_pending   <= n_pending;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
        end
    end

    // an accepted transfer always starts the setup step
    a_accept_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == S_SETUP))
        else $error("accepted transfer did not enter setup");

    // last divider step hands over to the update
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_cnt == '0) |=> (r_state == S_UPDATE))
        else $error("divider did not finish after last step");

    // an unforced tick with a pending jump takes the jump and clears the flag
    a_jump_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SETUP && !i_status.forced && r_pending)
        |=> (r_mode == MODE_JUMP && !r_pending))
        else $error("pending jump not taken");

    // a held result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUBLISH && r_out_valid && i_out_stall)
        |=> (r_state == S_PUBLISH && r_out_valid))
        else $error("result overwritten while stalled");

endmodule

FILE: hw/rtl/rlsf_dp.sv
module rlsf_dp #(
    parameter int MAX_STEP = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rlsf_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  logic [rlsf_pkg::CfgDataW-1:0]  i_cfg_data,
    input  logic [rlsf_pkg::CoordW-1:0]    i_object_x,
    input  logic [rlsf_pkg::CoordW-1:0]    i_object_y,
    input  logic [rlsf_pkg::ForcedW-1:0]   i_forced_x,
    input  logic [rlsf_pkg::ForcedW-1:0]   i_forced_y,
    input  rlsf_pkg::t_cmd                 i_cmd,
    output rlsf_pkg::t_status              o_status,
    output logic [rlsf_pkg::CoordW-1:0]    o_view_x,
    output logic [rlsf_pkg::CoordW-1:0]    o_view_y
);
    import rlsf_pkg::*;

    // configuration
    logic [CoordW-1:0] r_anchor_x, r_anchor_y, r_max_x, r_max_y;
    logic [DivW-1:0]   r_catchup;
    logic [DivW-1:0]   eff_div;

    // per-tick operands
    logic [CoordW-1:0] r_tgt_x, r_tgt_y, r_fc_x, r_fc_y;
    logic              r_forced;
    logic [CoordW-1:0] tgt_x, tgt_y, fc_x, fc_y;

    // divider lanes
    logic [CoordW-1:0] r_quo_x, r_quo_y;
    logic [DivW-1:0]   r_rem_x, r_rem_y;
    logic              r_neg_x, r_neg_y, r_zero_x, r_zero_y;
    logic [DivW:0]     trial_x, trial_y;
    logic              ge_x, ge_y;
    logic [DivW:0]     diff_x, diff_y;

    // scroll state and output register
    logic [CoordW-1:0] r_scroll_x, r_scroll_y;
    logic [CoordW-1:0] r_out_x, r_out_y;

    // target offset: object minus anchor, clamped to 0..max
    function automatic logic [CoordW-1:0] f_target(
        input logic [CoordW-1:0] obj,
        input logic [CoordW-1:0] anchor,
        input logic [CoordW-1:0] maxv
    );
        logic [CoordW:0] d;
        d = {1'b0, obj} - {1'b0, anchor};
        if (d[CoordW]) begin
            return '0;
        end else if (d[CoordW-1:0] > maxv) begin
            return maxv;
        end
        return d[CoordW-1:0];
    endfunction

    // forced value clamped to the axis maximum
    function automatic logic [CoordW-1:0] f_clamp(
        input logic [ForcedW-1:0] f,
        input logic [CoordW-1:0]  maxv
    );
        if (f < ForcedW'(maxv)) begin
            return f[CoordW-1:0];
        end
        return maxv;
    endfunction

    // one step toward the target, capped and saturated
    function automatic logic [CoordW-1:0] f_follow(
        input logic [CoordW-1:0] cur,
        input logic [CoordW-1:0] q,
        input logic              neg,
        input logic              zero
    );
        logic [StepW-1:0] step;
        logic [CoordW:0]  sum;
        if (q >= CoordW'(MAX_STEP - 1)) begin
            step = StepW'(MAX_STEP);
        end else begin
            step = q[StepW-1:0] + StepW'(1);
        end
        sum = {1'b0, cur} + (CoordW+1)'(step);
        if (zero) begin
            return cur;
        end else if (neg) begin
            return sum[CoordW] ? '1 : sum[CoordW-1:0];
        end else if (CoordW'(step) > cur) begin
            return '0;
        end
        return cur - CoordW'(step);
    endfunction

    assign eff_div = (r_catchup == '0) ? DivW'(1) : r_catchup;
    assign tgt_x   = f_target(i_object_x, r_anchor_x, r_max_x);
    assign tgt_y   = f_target(i_object_y, r_anchor_y, r_max_y);
    assign fc_x    = f_clamp(i_forced_x, r_max_x);
    assign fc_y    = f_clamp(i_forced_y, r_max_y);

    // restoring divide: shift one dividend bit into the remainder per step
    assign trial_x = {r_rem_x, r_quo_x[CoordW-1]};
    assign trial_y = {r_rem_y, r_quo_y[CoordW-1]};
    assign ge_x    = (trial_x >= {1'b0, eff_div});
    assign ge_y    = (trial_y >= {1'b0, eff_div});
    assign diff_x  = trial_x - {1'b0, eff_div};
    assign diff_y  = trial_y - {1'b0, eff_div};

    assign o_status.forced = r_forced;
    assign o_view_x        = r_out_x;
    assign o_view_y        = r_out_y;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_anchor_x <= '0;
            r_anchor_y <= '0;
            r_max_x    <= '0;
            r_max_y    <= '0;
            r_catchup  <= DivReset;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ANCHOR_X: r_anchor_x <= i_cfg_data;
                REG_ANCHOR_Y: r_anchor_y <= i_cfg_data;
                REG_MAX_X:    r_max_x    <= i_cfg_data;
                REG_MAX_Y:    r_max_y    <= i_cfg_data;
                REG_CATCHUP:  r_catchup  <= i_cfg_data[DivW-1:0];
                default: ;
            endcase
        end
    end

    // input capture: targets and clamped forced values
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_tgt_x  <= tgt_x;
            r_tgt_y  <= tgt_y;
            r_fc_x   <= fc_x;
            r_fc_y   <= fc_y;
            r_forced <= (i_forced_x != '0) || (i_forced_y != '0);
        end
    end

    // distance setup and divider iterations
    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_neg_x  <= (r_scroll_x < r_tgt_x);
            r_neg_y  <= (r_scroll_y < r_tgt_y);
            r_zero_x <= (r_scroll_x == r_tgt_x);
            r_zero_y <= (r_scroll_y == r_tgt_y);
            r_quo_x  <= (r_scroll_x < r_tgt_x) ? r_tgt_x - r_scroll_x
                                               : r_scroll_x - r_tgt_x;
            r_quo_y  <= (r_scroll_y < r_tgt_y) ? r_tgt_y - r_scroll_y
                                               : r_scroll_y - r_tgt_y;
            r_rem_x  <= '0;
            r_rem_y  <= '0;
        end else if (i_cmd.div_step) begin
            r_rem_x <= ge_x ? diff_x[DivW-1:0] : trial_x[DivW-1:0];
            r_rem_y <= ge_y ? diff_y[DivW-1:0] : trial_y[DivW-1:0];
            r_quo_x <= {r_quo_x[CoordW-2:0], ge_x};
            r_quo_y <= {r_quo_y[CoordW-2:0], ge_y};
        end
    end

    // scroll state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scroll_x <= '0;
            r_scroll_y <= '0;
        end else if (i_cmd.update) begin
            unique case (i_cmd.mode)
                MODE_FORCE: begin
                    r_scroll_x <= r_fc_x;
                    r_scroll_y <= r_fc_y;
                end
                MODE_JUMP: begin
                    r_scroll_x <= r_tgt_x;
                    r_scroll_y <= r_tgt_y;
                end
                MODE_FOLLOW: begin
                    r_scroll_x <= f_follow(r_scroll_x, r_quo_x, r_neg_x, r_zero_x);
                    r_scroll_y <= f_follow(r_scroll_y, r_quo_y, r_neg_y, r_zero_y);
                end
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_x <= r_scroll_x;
            r_out_y <= r_scroll_y;
        end
    end

endmodule

FILE: hw/rtl/rate_limited_scroll_follow.sv
// A forced or jump tick passes through the setup, update and publish states before
// its result is presented; a follow tick also runs the bit-serial distance divider
// (both axes divided side by side, one quotient bit per cycle).
// A new item is taken only once the previous one has been published, though that
// result may still wait in the output register.
// Reset (synchronous, active low): offsets 0, jump pending, divisor 16.
module rate_limited_scroll_follow #(
    parameter int MAX_STEP = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rlsf_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  logic [rlsf_pkg::CfgDataW-1:0]  i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [rlsf_pkg::CoordW-1:0]    i_object_x,
    input  logic [rlsf_pkg::CoordW-1:0]    i_object_y,
    input  logic [rlsf_pkg::ForcedW-1:0]   i_forced_x,
    input  logic [rlsf_pkg::ForcedW-1:0]   i_forced_y,
    input  logic                           i_new_screen,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [rlsf_pkg::CoordW-1:0]    o_view_x,
    output logic [rlsf_pkg::CoordW-1:0]    o_view_y
);
    import rlsf_pkg::*;

    t_cmd    cmd;
    t_status status;

    // sequencer
    rlsf_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_new_screen (i_new_screen),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_status     (status),
        .o_cmd        (cmd)
    );

    // targets, divider lanes, scroll state
    rlsf_dp #(
        .MAX_STEP (MAX_STEP)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_object_x (i_object_x),
        .i_object_y (i_object_y),
        .i_forced_x (i_forced_x),
        .i_forced_y (i_forced_y),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_view_x   (o_view_x),
        .o_view_y   (o_view_y)
    );

endmodule

FILE: dv/rate_limited_scroll_follow_tb.sv
module rate_limited_scroll_follow_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rlsf_pkg::*;

    localparam int MaxStep    = 8;
    localparam int NumDrill   = 37;
    localparam int NumPhases  = 6;
    localparam int PhaseItems = 321;
    localparam int LongHold   = 150;
    localparam int HoldAtA    = 200;
    localparam int HoldAtB    = 1200;

    // index past the last register: writes to it must be ignored
    localparam logic [CfgIdxW-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic [CoordW-1:0]  obj_x;
        logic [CoordW-1:0]  obj_y;
        logic [ForcedW-1:0] frc_x;
        logic [ForcedW-1:0] frc_y;
        logic               new_scr;
    } t_tick;

    typedef struct packed {
        logic [CoordW-1:0] x;
        logic [CoordW-1:0] y;
    } t_scroll_pair;

    typedef enum logic {
        ROW_TICK,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        t_row_kind           kind;
        logic [CfgIdxW-1:0]  reg_idx;
        logic [CfgDataW-1:0] reg_val;
        t_tick               tick;
        logic                check;
        t_scroll_pair        want;
    } t_drill_row;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                cfg_we   = 1'b0;
    logic [CfgIdxW-1:0]  cfg_idx  = '0;
    logic [CfgDataW-1:0] cfg_data = '0;
    logic                in_valid = 1'b0;
    logic [CoordW-1:0]   obj_x    = '0;
    logic [CoordW-1:0]   obj_y    = '0;
    logic [ForcedW-1:0]  frc_x    = '0;
    logic [ForcedW-1:0]  frc_y    = '0;
    logic                new_scr  = 1'b0;
    logic                out_stall = 1'b0;
    logic                in_stall;
    logic                out_valid;
    logic [CoordW-1:0]   off_x;
    logic [CoordW-1:0]   off_y;

    // shadow of the register file and the scroll state
    logic [CoordW-1:0] cur_anchor_x = '0;
    logic [CoordW-1:0] cur_anchor_y = '0;
    logic [CoordW-1:0] cur_max_x    = '0;
    logic [CoordW-1:0] cur_max_y    = '0;
    logic [DivW-1:0]   cur_divisor  = DivReset;
    logic [CoordW-1:0] cam_x        = '0;
    logic [CoordW-1:0] cam_y        = '0;
    logic              jump_armed   = 1'b1;

    t_scroll_pair pending_offsets[$];
    t_scroll_pair head_offset;
    t_drill_row   drill_tab [NumDrill];
    bit           no_idle   = 1'b0;
    int           n_errors  = 0;
    int           xfers     = 0;
    int           pause     = 0;

    rate_limited_scroll_follow #(
        .MAX_STEP (MaxStep)
    ) u_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_object_x   (obj_x),
        .i_object_y   (obj_y),
        .i_forced_x   (frc_x),
        .i_forced_y   (frc_y),
        .i_new_screen (new_scr),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_view_x     (off_x),
        .o_view_y     (off_y)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic note_error(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        n_errors++;
    endtask

    function automatic int clip15(input int v);
        if (v < 0) return 0;
        if (v > 32767) return 32767;
        return v;
    endfunction

    // target offset: object minus anchor, held inside 0..limit
    function automatic int aim(input logic [CoordW-1:0] obj, input logic [CoordW-1:0] anchor,
                               input logic [CoordW-1:0] lim);
        int o, a, m, v;
        o = obj;
        a = anchor;
        m = lim;
        v = o - a;
        if (v < 0) return 0;
        if (v > m) return m;
        return v;
    endfunction

    // one follow step: 1 + |distance|/div, capped, saturating at the ends
    function automatic logic [CoordW-1:0] chase(input logic [CoordW-1:0] cur, input int tgt,
                                                input int div);
        int c, d, mag, stepv;
        c = cur;
        d = c - tgt;
        mag = (d < 0) ? -d : d;
        if (d == 0) return cur;
        stepv = 1 + mag / div;
        if (stepv > MaxStep) stepv = MaxStep;
        return 15'(clip15((d < 0) ? c + stepv : c - stepv));
    endfunction

    // scroll state after one accepted tick
    function automatic void advance_scroll(input t_tick t, output t_scroll_pair nxt);
        int tx, ty, div;
        if (t.new_scr) jump_armed = 1'b1;
        if (t.frc_x != '0 || t.frc_y != '0) begin
            // forced: both axes take the scripted values, clamped; jump flag untouched
            cam_x = (t.frc_x < cur_max_x) ? t.frc_x[CoordW-1:0] : cur_max_x;
            cam_y = (t.frc_y < cur_max_y) ? t.frc_y[CoordW-1:0] : cur_max_y;
        end else begin
            tx = aim(t.obj_x, cur_anchor_x, cur_max_x);
            ty = aim(t.obj_y, cur_anchor_y, cur_max_y);
            if (jump_armed) begin
                cam_x = 15'(tx);
                cam_y = 15'(ty);
                jump_armed = 1'b0;
            end else begin
                div = (cur_divisor == '0) ? 1 : int'(cur_divisor);
                cam_x = chase(cam_x, tx, div);
                cam_y = chase(cam_y, ty, div);
            end
        end
        nxt.x = cam_x;
        nxt.y = cam_y;
    endfunction

    function automatic logic [CfgDataW-1:0] pick15();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            default: return 15'($urandom);
        endcase
    endfunction

    // half the ticks track the current scroll, so their distances stay small
    function automatic t_tick roll_tick();
        t_tick t;
        int ox, oy;
        t = '0;
        case ($urandom_range(0, 3))
            0: begin
                ox = $urandom_range(0, 32767);
                oy = $urandom_range(0, 32767);
            end
            3: begin
                ox = cur_anchor_x + $urandom_range(0, cur_max_x);
                oy = cur_anchor_y + $urandom_range(0, cur_max_y);
            end
            default: begin
                ox = cur_anchor_x + cam_x + $urandom_range(0, 48) - 24;
                oy = cur_anchor_y + cam_y + $urandom_range(0, 48) - 24;
            end
        endcase
        t.obj_x = 15'(clip15(ox));
        t.obj_y = 15'(clip15(oy));
        if ($urandom_range(0, 9) == 0) begin
            t.frc_x = ($urandom_range(0, 2) == 0) ? '0 : 16'($urandom);
            t.frc_y = ($urandom_range(0, 2) == 0) ? '0 : 16'($urandom);
        end
        t.new_scr = ($urandom_range(0, 11) == 0);
        return t;
    endfunction

    task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_ANCHOR_X: cur_anchor_x = val;
            REG_ANCHOR_Y: cur_anchor_y = val;
            REG_MAX_X:    cur_max_x    = val;
            REG_MAX_Y:    cur_max_y    = val;
            REG_CATCHUP:  cur_divisor  = val[DivW-1:0];
            default: ;
        endcase
    endtask

    // offer one tick, wait for the transfer, then queue what should come out
    task automatic send_tick(input t_tick t, input bit typed, input t_scroll_pair typed_val);
        int gap;
        t_scroll_pair predicted;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        obj_x    <= t.obj_x;
        obj_y    <= t.obj_y;
        frc_x    <= t.frc_x;
        frc_y    <= t.frc_y;
        new_scr  <= t.new_scr;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        advance_scroll(t, predicted);
        pending_offsets.push_back(typed ? typed_val : predicted);
    endtask

    // block is idle once every queued offset has come out
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_offsets.size() != 0) @(posedge clk);
    endtask

    task automatic load_phase_regs(input int p);
        logic [CfgDataW-1:0] dval;
        cfg_write(REG_ANCHOR_X, pick15());
        cfg_write(REG_ANCHOR_Y, pick15());
        cfg_write(REG_MAX_X, pick15());
        cfg_write(REG_MAX_Y, pick15());
        case ($urandom_range(0, 4))
            0: dval = 15'd0;
            1: dval = 15'd1;
            2: dval = 15'd16;
            3: dval = 15'd32;
            default: dval = 15'($urandom);
        endcase
        cfg_write(REG_CATCHUP, dval);
        if (p == 2) cfg_write(REG_UNUSED, 15'($urandom));
    endtask

    // result side: check each transfer, then draw the next hold-off
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            xfers++;
            if (pending_offsets.size() == 0) begin
                note_error($sformatf("unexpected offsets %0d,%0d", off_x, off_y));
            end else begin
                head_offset = pending_offsets.pop_front();
                if (off_x !== head_offset.x)
                    note_error($sformatf("transfer %0d view_x %0d, want %0d",
                                         xfers, off_x, head_offset.x));
                if (off_y !== head_offset.y)
                    note_error($sformatf("transfer %0d view_y %0d, want %0d",
                                         xfers, off_y, head_offset.y));
            end
            pause = no_idle ? 0 : $urandom_range(0, 9);
            // long hold-off so the block backs up into its input
            if (xfers == HoldAtA || xfers == HoldAtB) pause = LongHold;
        end
        if (pause > 0) begin
            out_stall <= 1'b1;
            pause--;
        end else begin
            out_stall <= 1'b0;
        end
    end

    initial begin
        // kind, reg, value, {obj_x, obj_y, forced_x, forced_y, new}, check, {want_x, want_y}
        drill_tab = '{
            '{ROW_TICK, 0, 0, '{32767, 32767, 0, 0, 0}, 1, '{0, 0}},
            '{ROW_TICK, 0, 0, '{0, 0, 16'hFFFF, 16'hFFFF, 0}, 1, '{0, 0}},
            '{ROW_CFG, REG_ANCHOR_X, 100, '{0, 0, 0, 0, 0}, 0, '{0, 0}},
            '{ROW_CFG, REG_ANCHOR_Y, 50, '{0, 0, 0, 0, 0}, 0, '{0, 0}},
            '{ROW_CFG, REG_MAX_X, 32767, '{0, 0, 0, 0, 0}, 0, '{0, 0}},
            '{ROW_CFG, REG_MAX_Y, 32767, '{0, 0, 0, 0, 0}, 0, '{0, 0}},
            '{ROW_CFG, REG_CATCHUP, 16, '{0, 0, 0, 0, 0}, 0, '{0, 0}},
            '{ROW_TICK, 0, 0, '{0, 0, 0, 0, 0}, 1, '{0, 0}},
            '{ROW_TICK, 0, 0, '{32767, 32767, 0, 0, 1}, 1, '{32667, 32717}},
            '{ROW_TICK, 0, 0, '{32767, 32767, 0, 0, 0}, 1, '{32667, 32717}},
            '{ROW_TICK, 0, 0, '{0, 0, 0, 0, 0}, 1, '{32659, 32709}},
            '{ROW_TICK, 0, 0, '{0, 0, 16'hFFFF, 0, 0}, 1, '{32767, 0}},
            '{ROW_TICK, 0, 0, '{0, 0, 0, 1, 0}, 1, '{0, 1}},
            '{ROW_TICK, 0, 0, '{0, 0, 16'h8000, 16'h7FFF, 0}, 1, '{32767, 32767}},
            '{ROW_TICK, 0, 0, '{132, 82, 0, 0, 0}, 1, '{32759, 32759}},
            '{ROW_TICK, 0, 0, '{0, 0, 5, 7, 1}, 1, '{5, 7}},
            '{ROW_TICK, 0, 0, '{132, 82, 0, 0, 0}, 1, '{32, 32}},
            '{ROW_TICK, 0, 0, '{150, 50, 0, 0, 0}, 0, '{0, 0}},
            '{ROW_CFG, REG_CATCHUP, 0, '{0, 0, 0, 0, 0}, 0, '{0, 0}},
            '{ROW_TICK, 0, 0, '{150, 50, 0, 0, 0}, 0, '{0, 0}},
            '{ROW_CFG, REG_CATCHUP, 1, '{0, 0, 0, 0, 0}, 0, '{0, 0}},
            '{ROW_CFG, REG_ANCHOR_Y, 0, '{0, 0, 0, 0, 0}, 0, '{0, 0}},
            '{ROW_TICK, 0, 0, '{0, 0, 3, 32765, 0}, 1, '{3, 32765}},
            '{ROW_TICK, 0, 0, '{0, 32767, 0, 0, 0}, 1, '{0, 32767}},
            '{ROW_TICK, 0, 0, '{0, 0, 20000, 100, 0}, 1, '{20000, 100}},
            '{ROW_CFG, REG_MAX_X, 10, '{0, 0, 0, 0, 0}, 0, '{0, 0}},
            '{ROW_CFG, REG_MAX_Y, 0, '{0, 0, 0, 0, 0}, 0, '{0, 0}},
            '{ROW_CFG, REG_CATCHUP, 16, '{0, 0, 0, 0, 0}, 0, '{0, 0}},
            '{ROW_TICK, 0, 0, '{32767, 0, 0, 0, 0}, 0, '{0, 0}},
            '{ROW_TICK, 0, 0, '{50, 200, 0, 0, 0}, 0, '{0, 0}},
            '{ROW_TICK, 0, 0, '{5, 5, 0, 0, 1}, 1, '{0, 0}},
            '{ROW_CFG, REG_ANCHOR_X, 32767, '{0, 0, 0, 0, 0}, 0, '{0, 0}},
            '{ROW_CFG, REG_MAX_X, 32767, '{0, 0, 0, 0, 0}, 0, '{0, 0}},
            '{ROW_CFG, REG_UNUSED, 15'h7FFF, '{0, 0, 0, 0, 0}, 0, '{0, 0}},
            '{ROW_CFG, REG_CATCHUP, 15'h7FFF, '{0, 0, 0, 0, 0}, 0, '{0, 0}},
            '{ROW_TICK, 0, 0, '{32767, 32767, 0, 0, 1}, 1, '{0, 0}},
            '{ROW_TICK, 0, 0, '{12345, 0, 0, 0, 0}, 0, '{0, 0}}
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed rows; register writes only once the block has drained
        for (int i = 0; i < NumDrill; i++) begin
            if (drill_tab[i].kind == ROW_CFG) begin
                settle();
                cfg_write(drill_tab[i].reg_idx, drill_tab[i].reg_val);
            end else begin
                send_tick(drill_tab[i].tick, drill_tab[i].check, drill_tab[i].want);
            end
        end

        // random phases, each under a fresh register setting
        for (int p = 0; p < NumPhases; p++) begin
            settle();
            no_idle = (p == 1 || p == 4);
            load_phase_regs(p);
            for (int n = 0; n < PhaseItems; n++)
                send_tick(roll_tick(), 1'b0, '0);
        end

        in_valid <= 1'b0;
        for (int n = 0; n < 4000 && pending_offsets.size() != 0; n++) @(posedge clk);
        repeat (30) @(posedge clk);
        if (pending_offsets.size() != 0)
            note_error($sformatf("%0d offsets never came out", pending_offsets.size()));
        if (n_errors == 0) begin
            $display("rate_limited_scroll_follow_tb: clean");
        end else begin
            $display("rate_limited_scroll_follow_tb: errors");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(5_000_000);
        $display("rate_limited_scroll_follow_tb: errors");
        $finish;
    end

endmodule
